// ===== rtl/core/buddy_block_allocator_assert.svh =====
// ============================================================================
// Buddy block allocator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ============================================================================
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
// ============================================================================
// Buddy block allocator package
// Field widths, status codes, result record and sequencer states.
// ============================================================================
`default_nettype none

package bba_pkg;

    // Fixed field widths of the request and result channels.
    localparam int STATUS_W    = 3;
    localparam int INDEX_W     = 6;
    localparam int ORDER_OUT_W = 5;
    localparam int OWNER_W     = 16;
    localparam int COUNT_OUT_W = 7;
    localparam int SIZE_W      = 32;
    localparam int CFG_W       = 5;
    // A rounded order never exceeds 32, so six bits hold it.
    localparam int K_W         = 6;
    // Common width for comparing orders of different widths.
    localparam int EXT_W       = 8;

    // Total order after reset.
    localparam int TOTAL_ORDER_RESET = 20;

    typedef logic [STATUS_W-1:0]    status_t;
    typedef logic [INDEX_W-1:0]     index_t;
    typedef logic [ORDER_OUT_W-1:0] order_out_t;
    typedef logic [OWNER_W-1:0]     owner_t;
    typedef logic [COUNT_OUT_W-1:0] count_out_t;
    typedef logic [SIZE_W-1:0]      size_t;
    typedef logic [CFG_W-1:0]       cfg_t;
    typedef logic [K_W-1:0]         k_t;
    typedef logic [EXT_W-1:0]       ext_t;

    // Result status codes.
    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_NOFIT = 3'd1;
    localparam status_t ST_FULL  = 3'd2;
    localparam status_t ST_BADID = 3'd3;
    localparam status_t ST_QUERY = 3'd4;

    // One result record.
    typedef struct packed {
        status_t    status;
        index_t     block_index;
        order_out_t block_order;
        owner_t     block_owner;
        count_out_t block_count;
        logic       last;
    } bba_res_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ORDER,
        S_SCAN,
        S_FIT,
        S_SHIFT,
        S_SHIFT_END,
        S_SPLIT,
        S_EMIT,
        S_QRD,
        S_QOUT
    } bba_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bba_req_if.sv =====
// ============================================================================
// Buddy block allocator request channel
// Valid/ready channel that carries one allocate or query request.
// ============================================================================
`default_nettype none

interface bba_req_if;
    logic                valid;
    logic                ready;
    logic                mode;
    bba_pkg::owner_t     owner_id;
    bba_pkg::size_t      request_size;

    modport source (output valid, output mode, output owner_id, output request_size,
                    input ready);
    modport sink   (input valid, input mode, input owner_id, input request_size,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bba_rsp_if.sv =====
// ============================================================================
// Buddy block allocator result channel
// Valid/ready channel that carries one allocation status or table entry.
// ============================================================================
`default_nettype none

interface bba_rsp_if;
    logic                  valid;
    logic                  ready;
    bba_pkg::status_t      status;
    bba_pkg::index_t       block_index;
    bba_pkg::order_out_t   block_order;
    bba_pkg::owner_t       block_owner;
    bba_pkg::count_out_t   block_count;
    logic                  last;

    modport source (output valid, output status, output block_index, output block_order,
                    output block_owner, output block_count, output last, input ready);
    modport sink   (input valid, input status, input block_index, input block_order,
                    input block_owner, input block_count, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bba_table_mem.sv =====
// ============================================================================
// Buddy block table memory
// One write port and one registered read port holding owner and order.
// ============================================================================
`default_nettype none

module bba_table_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 21
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bba_ctrl.sv =====
// ============================================================================
// Buddy block allocator sequencer
// Rounds, scans, shifts the tail and writes the split; answers queries.
// ============================================================================
`default_nettype none

module bba_ctrl #(
    parameter int MAX_BLOCKS  = 64,
    parameter int ORDER_LIMIT = 31,
    parameter int AW          = 6,
    parameter int CW          = 7,
    parameter int OW          = 5
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    bba_req_if.sink                       req,
    input  wire logic                     cfg_we,
    input  wire bba_pkg::cfg_t            cfg_wdata,
    output logic                          res_valid,
    output bba_pkg::bba_res_t             res,
    input  wire logic                     res_ack,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  wire logic [bba_pkg::OWNER_W+OW-1:0] rd_data,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [bba_pkg::OWNER_W+OW-1:0] wr_data,
    output logic [CW-1:0]                 entry_count
);

    localparam int XW      = ((CW > OW) ? CW : OW) + 1;
    localparam int TO_RST  = (ORDER_LIMIT < bba_pkg::TOTAL_ORDER_RESET) ?
                             ORDER_LIMIT : bba_pkg::TOTAL_ORDER_RESET;

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] cnt_t;
    typedef logic [OW-1:0] ord_t;
    typedef logic [XW-1:0] sum_t;

    bba_pkg::bba_state_t state_reg, state_next;
    ord_t            total_order_reg, total_order_next;
    cnt_t            count_reg, count_next;
    logic            fresh_reg, fresh_next;
    logic            fresh_hit_reg;
    logic            pend_reg, pend_next;
    logic            issued_all_reg, issued_all_next;
    bba_pkg::owner_t id_reg, id_next;
    bba_pkg::size_t  v_reg, v_next;
    bba_pkg::k_t     k_reg, k_next;
    addr_t           idx_reg, idx_next;
    addr_t           pend_idx_reg, pend_idx_next;
    addr_t           j_reg, j_next;
    addr_t           sh_dest_reg, sh_dest_next;
    ord_t            a_reg, a_next;
    ord_t            extra_reg, extra_next;
    ord_t            wcnt_reg, wcnt_next;
    bba_pkg::bba_res_t res_reg, res_next;

    bba_pkg::owner_t rd_owner;
    ord_t            rd_order;
    ord_t            extra_calc;
    ord_t            k_ord;
    bba_pkg::count_out_t count_out;
    logic            idx_is_last;
    logic            pend_is_last;

    // Build a rejection record: everything zero but the status, count and last.
    function automatic bba_pkg::bba_res_t reject(input bba_pkg::status_t st,
                                                 input bba_pkg::count_out_t cnt);
        bba_pkg::bba_res_t r;
        r             = '0;
        r.status      = st;
        r.block_count = cnt;
        r.last        = 1'b1;
        return r;
    endfunction

    // Entry 0 reads as one free block of the total order until it is written.
    assign rd_owner = fresh_hit_reg ? bba_pkg::owner_t'(0) : rd_data[OW +: bba_pkg::OWNER_W];
    assign rd_order = fresh_hit_reg ? total_order_reg : rd_data[OW-1:0];

    assign k_ord        = ord_t'(k_reg);
    assign extra_calc   = a_reg - k_ord;
    assign count_out    = bba_pkg::count_out_t'(count_reg);
    assign idx_is_last  = (cnt_t'(idx_reg) + cnt_t'(1)) == count_reg;
    assign pend_is_last = (cnt_t'(pend_idx_reg) + cnt_t'(1)) == count_reg;
    assign entry_count  = count_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bba_pkg::S_IDLE;
            total_order_reg <= ord_t'(TO_RST);
            count_reg       <= cnt_t'(1);
            fresh_reg       <= 1'b1;
            fresh_hit_reg   <= 1'b0;
            pend_reg        <= 1'b0;
            issued_all_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            total_order_reg <= total_order_next;
            count_reg       <= count_next;
            fresh_reg       <= fresh_next;
            pend_reg        <= pend_next;
            issued_all_reg  <= issued_all_next;
            if (rd_en)
            begin
                fresh_hit_reg <= fresh_reg && (rd_addr == addr_t'(0));
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        v_reg        <= v_next;
        k_reg        <= k_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        j_reg        <= j_next;
        sh_dest_reg  <= sh_dest_next;
        a_reg        <= a_next;
        extra_reg    <= extra_next;
        wcnt_reg     <= wcnt_next;
        res_reg      <= res_next;
    end

    // Sequencer: next state, memory port and result.
    always_comb
    begin
        state_next       = state_reg;
        total_order_next = total_order_reg;
        count_next       = count_reg;
        fresh_next       = fresh_reg;
        pend_next        = pend_reg;
        issued_all_next  = issued_all_reg;
        id_next          = id_reg;
        v_next           = v_reg;
        k_next           = k_reg;
        idx_next         = idx_reg;
        pend_idx_next    = pend_idx_reg;
        j_next           = j_reg;
        sh_dest_next     = sh_dest_reg;
        a_next           = a_reg;
        extra_next       = extra_reg;
        wcnt_next        = wcnt_reg;
        res_next         = res_reg;

        req.ready = (state_reg == bba_pkg::S_IDLE);
        res_valid = 1'b0;
        res       = res_reg;
        rd_en     = 1'b0;
        rd_addr   = idx_reg;
        wr_en     = 1'b0;
        wr_addr   = sh_dest_reg;
        wr_data   = rd_data;

        case (state_reg)
            bba_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    id_next = req.owner_id;
                    k_next  = '0;
                    v_next  = (req.request_size == '0) ? '0 :
                              req.request_size - bba_pkg::size_t'(1);
                    idx_next = '0;
                    if (req.mode)
                    begin
                        state_next = bba_pkg::S_QRD;
                    end
                    else if (req.owner_id == '0)
                    begin
                        res_next   = reject(bba_pkg::ST_BADID, count_out);
                        state_next = bba_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = bba_pkg::S_ORDER;
                    end
                end
            end

            // One bit of the size a cycle: k is the bit length of size minus one.
            bba_pkg::S_ORDER:
            begin
                if (v_reg != '0)
                begin
                    v_next = v_reg >> 1;
                    k_next = k_reg + bba_pkg::k_t'(1);
                end
                else if (bba_pkg::ext_t'(k_reg) > bba_pkg::ext_t'(ORDER_LIMIT))
                begin
                    res_next   = reject(bba_pkg::ST_NOFIT, count_out);
                    state_next = bba_pkg::S_EMIT;
                end
                else
                begin
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    issued_all_next = 1'b0;
                    state_next      = bba_pkg::S_SCAN;
                end
            end

            // Reads are issued one a cycle and checked the cycle after.
            bba_pkg::S_SCAN:
            begin
                if (pend_reg && (rd_owner == '0) &&
                    (bba_pkg::ext_t'(rd_order) >= bba_pkg::ext_t'(k_reg)))
                begin
                    j_next     = pend_idx_reg;
                    a_next     = rd_order;
                    pend_next  = 1'b0;
                    state_next = bba_pkg::S_FIT;
                end
                else if (pend_reg && pend_is_last)
                begin
                    pend_next  = 1'b0;
                    res_next   = reject(bba_pkg::ST_NOFIT, count_out);
                    state_next = bba_pkg::S_EMIT;
                end
                else if (!issued_all_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = idx_reg;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    if (idx_is_last)
                    begin
                        issued_all_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + addr_t'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            // Check room for the split, then decide whether the tail moves.
            bba_pkg::S_FIT:
            begin
                if ((sum_t'(count_reg) + sum_t'(extra_calc)) > sum_t'(MAX_BLOCKS))
                begin
                    res_next   = reject(bba_pkg::ST_FULL, count_out);
                    state_next = bba_pkg::S_EMIT;
                end
                else
                begin
                    extra_next = extra_calc;
                    wcnt_next  = '0;
                    pend_next  = 1'b0;
                    if ((extra_calc != '0) && ((cnt_t'(j_reg) + cnt_t'(1)) < count_reg))
                    begin
                        idx_next   = addr_t'(count_reg - cnt_t'(1));
                        state_next = bba_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = bba_pkg::S_SPLIT;
                    end
                end
            end

            // Tail move, last entry first: read one entry, write the one read before.
            bba_pkg::S_SHIFT:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = sh_dest_reg;
                    wr_data = rd_data;
                end
                pend_next    = 1'b1;
                sh_dest_next = idx_reg + addr_t'(extra_reg);
                if (idx_reg == j_reg + addr_t'(1))
                begin
                    state_next = bba_pkg::S_SHIFT_END;
                end
                else
                begin
                    idx_next = idx_reg - addr_t'(1);
                end
            end

            bba_pkg::S_SHIFT_END:
            begin
                wr_en      = 1'b1;
                wr_addr    = sh_dest_reg;
                wr_data    = rd_data;
                pend_next  = 1'b0;
                state_next = bba_pkg::S_SPLIT;
            end

            // Claimed block first, then the free buddies of rising order.
            bba_pkg::S_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg + addr_t'(wcnt_reg);
                if (wcnt_reg == '0)
                begin
                    wr_data = {id_reg, k_ord};
                end
                else
                begin
                    wr_data = {bba_pkg::owner_t'(0), k_ord + wcnt_reg - ord_t'(1)};
                end
                if (wr_addr == addr_t'(0))
                begin
                    fresh_next = 1'b0;
                end
                if (wcnt_reg == extra_reg)
                begin
                    count_next           = count_reg + cnt_t'(extra_reg);
                    res_next.status      = bba_pkg::ST_OK;
                    res_next.block_index = bba_pkg::index_t'(j_reg);
                    res_next.block_order = bba_pkg::order_out_t'(k_ord);
                    res_next.block_owner = id_reg;
                    res_next.block_count =
                        bba_pkg::count_out_t'(count_reg + cnt_t'(extra_reg));
                    res_next.last        = 1'b1;
                    state_next           = bba_pkg::S_EMIT;
                end
                else
                begin
                    wcnt_next = wcnt_reg + ord_t'(1);
                end
            end

            bba_pkg::S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ack)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end

            bba_pkg::S_QRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = bba_pkg::S_QOUT;
            end

            // Report one entry; the read data holds while the output stalls.
            bba_pkg::S_QOUT:
            begin
                res_valid       = 1'b1;
                res.status      = bba_pkg::ST_QUERY;
                res.block_index = bba_pkg::index_t'(idx_reg);
                res.block_order = bba_pkg::order_out_t'(rd_order);
                res.block_owner = rd_owner;
                res.block_count = count_out;
                res.last        = idx_is_last;
                if (res_ack)
                begin
                    if (idx_is_last)
                    begin
                        state_next = bba_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + addr_t'(1);
                        state_next = bba_pkg::S_QRD;
                    end
                end
            end

            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase

        // A total order write starts over with one free block.
        if (cfg_we)
        begin
            total_order_next = (bba_pkg::ext_t'(cfg_wdata) > bba_pkg::ext_t'(ORDER_LIMIT)) ?
                               ord_t'(ORDER_LIMIT) : ord_t'(cfg_wdata);
            count_next       = cnt_t'(1);
            fresh_next       = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/buddy_block_allocator.sv =====
// ============================================================================
// Buddy block allocator
// Address-ordered table of buddy blocks with allocate and query requests.
// ============================================================================
//
//   Channel  Dir  Handshake        Payload
//   req      in   valid / ready    mode, owner_id, request_size
//   rsp      out  valid / ready    status, block_index, block_order,
//                                  block_owner, block_count, last
//   cfg      in   cfg_we           cfg_wdata (total_order)
//
// An allocate runs in order: B shifts, B being the bit length of the size
// minus one (one shift per cycle), N entries scanned (one read per cycle),
// S tail entries moved and E entries written by the split, all through the
// one table memory with its single read port and single write port.
// A query reads each table entry and then reports it, one result per entry.
// After reset: one free block of order min(20, ORDER_LIMIT); no clearing pass.
// A stalled result output stops the sequencer; one finished result waits in
// the output register while the next request is taken.
`default_nettype none

module buddy_block_allocator #(
    parameter int MAX_BLOCKS  = 64,
    parameter int ORDER_LIMIT = 31
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bba_req_if.sink            req,
    bba_rsp_if.source          rsp,
    input  wire logic          cfg_we,
    input  wire bba_pkg::cfg_t cfg_wdata
);

`include "buddy_block_allocator_assert.svh"

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int OW = $clog2(ORDER_LIMIT + 1);
    localparam int DW = bba_pkg::OWNER_W + OW;

    typedef logic [CW-1:0] cnt_t;

    logic              res_valid;
    logic              res_ack;
    bba_pkg::bba_res_t res;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DW-1:0]     rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DW-1:0]     wr_data;
    logic [CW-1:0]     entry_count;

    logic              out_valid_reg, out_valid_next;
    bba_pkg::bba_res_t out_reg;

    bba_table_mem #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bba_ctrl #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .ORDER_LIMIT (ORDER_LIMIT),
        .AW          (AW),
        .CW          (CW),
        .OW          (OW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .res_valid   (res_valid),
        .res         (res),
        .res_ack     (res_ack),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .entry_count (entry_count)
    );

    // Output register: loads when empty or when its result is taken.
    assign res_ack = res_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.block_index = out_reg.block_index;
    assign rsp.block_order = out_reg.block_order;
    assign rsp.block_owner = out_reg.block_owner;
    assign rsp.block_count = out_reg.block_count;
    assign rsp.last        = out_reg.last;

    // The sequencer works on one request at a time.
    `BBA_ASSERT_NEXT(a_busy_after_request, clk, rst_n, req.valid && req.ready,
                     !req.ready, "request taken while busy")
    // A result under way keeps new requests out.
    `BBA_ASSERT_NOW(a_result_blocks_request, clk, rst_n, res_valid, !req.ready,
                    "request ready while a result is pending")
    // The table never empties and never overflows.
    `BBA_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1,
                    (entry_count >= cnt_t'(1)) && (entry_count <= cnt_t'(MAX_BLOCKS)),
                    "entry count out of range")
    // Allocate results come one per request.
    `BBA_ASSERT_NOW(a_alloc_single, clk, rst_n,
                    rsp.valid && (rsp.status != bba_pkg::ST_QUERY), rsp.last,
                    "allocate result without last")

endmodule

`default_nettype wire
